>>> src/ute_pkg.sv
// Package for the UTF-8 to numeric character reference escaper.
// Holds the job record passed from the front to the back, character codes and helpers.
// Depends on nothing; every module of the block imports it.
package ute_pkg;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_BYTE_MODE_ADDR = 2'd0;

   // ASCII characters used in the escaped text.
   localparam logic [6:0] CH_AMP     = 7'h26;
   localparam logic [6:0] CH_HASH    = 7'h23;
   localparam logic [6:0] CH_X       = 7'h78;
   localparam logic [6:0] CH_SEMI    = 7'h3B;
   localparam logic [6:0] CH_ZERO    = 7'h30;
   localparam logic [6:0] CH_UPPER_A = 7'h41;
   localparam logic [6:0] CH_LOWER_A = 7'h61;
   localparam logic [6:0] CH_LOWER_M = 7'h6D;
   localparam logic [6:0] CH_LOWER_P = 7'h70;
   localparam logic [7:0] BYTE_AMP   = 8'h26;

   // Lengths of the character runs, in characters.
   localparam logic [3:0] PLAIN_LEN     = 4'd1;
   localparam logic [3:0] AMP_LEN       = 4'd5;
   localparam logic [3:0] REF_FIXED_LEN = 4'd4;
   localparam logic [3:0] REF_MIN_LEN   = 4'd8;
   localparam logic [3:0] MAX_LEN       = 4'd12;

   typedef enum logic [1:0] {
      JOB_PLAIN = 2'd0,
      JOB_AMP   = 2'd1,
      JOB_REF   = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [6:0]   ch;
      logic [31:0]  code;
      logic         upper;
      logic [3:0]   len;
   } job_type;

   typedef struct packed {
      logic clear;
      logic byte_mode;
   } cfg_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib, input logic upper);
      logic [6:0] base;
      if (nib < 4'd10) begin
         return CH_ZERO + {3'b000, nib};
      end
      base = upper ? CH_UPPER_A : CH_LOWER_A;
      return base + {3'b000, nib} - 7'd10;
   endfunction

   function automatic logic [6:0] amp_char(input logic [2:0] idx);
      logic [6:0] ch;
      case (idx)
         3'd0:    ch = CH_AMP;
         3'd1:    ch = CH_LOWER_A;
         3'd2:    ch = CH_LOWER_M;
         3'd3:    ch = CH_LOWER_P;
         default: ch = CH_SEMI;
      endcase
      return ch;
   endfunction

   // Number of hex digits: four at least, no leading zeros beyond that.
   function automatic logic [3:0] ref_digits(input logic [31:0] code);
      logic [3:0] d;
      if (code[31:28] != 4'd0) begin
         d = 4'd8;
      end else if (code[27:24] != 4'd0) begin
         d = 4'd7;
      end else if (code[23:20] != 4'd0) begin
         d = 4'd6;
      end else if (code[19:16] != 4'd0) begin
         d = 4'd5;
      end else begin
         d = 4'd4;
      end
      return d;
   endfunction

endpackage

>>> src/utf8_to_numeric_char_ref_escaper_top.sv
// Top level of the UTF-8 to numeric character reference escaper.
// Depends on ute_pkg, ute_front, ute_job_fifo and ute_back.
//
// Usage: text bytes enter as items on the req_ queue (push/full), one byte per item.
// Escaped ASCII characters leave as items on the rsp_ queue (empty/pop); run_last
// is high on the last character that an input byte causes. Bytes that cause
// nothing (a zero byte while idle, a lead or non-final continuation byte) give no item.
// The csr_ APB port holds byte_mode at address 0; writing it drops any partial
// UTF-8 sequence. Write it only while the block is idle.
// A byte's first character passes the job queue, then the output register, before
// it shows. Throughput: one output character per cycle while the receiver pops, set
// by the back part, which spells out one character of the head job whenever the
// output can take it. A plain byte gives one character; "&" gives five and a
// character reference eight to twelve, during which the two-entry job queue fills
// and full rises. Reset clears the sequence state, the job queue and the output
// valid flag, and sets byte_mode to zero. When the receiver stalls, the output
// register holds its character, the back part waits and the queue soon reports full.
module utf8_to_numeric_char_ref_escaper_top
   import ute_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [7:0]            req_text_byte,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [6:0]            rsp_out_char,
   output logic                  rsp_run_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic    byte_mode_ff;
   logic    csr_write;
   cfg_type cfg;
   logic    job_push;
   job_type job;
   logic    fifo_full;
   logic    head_valid;
   job_type head;
   logic    job_pop;

   // The register is written in the access phase; pready is tied high.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite
                     & (csr_paddr == CSR_BYTE_MODE_ADDR);
   assign csr_prdata = (csr_paddr == CSR_BYTE_MODE_ADDR) ?
                       {{(CSR_DATA_W-1){1'b0}}, byte_mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_mode_ff <= 1'b0;
      end else if (csr_write) begin
         byte_mode_ff <= csr_pwdata[0];
      end
   end

   // A write to byte_mode also clears the front's sequence state.
   assign cfg.clear     = csr_write;
   assign cfg.byte_mode = byte_mode_ff;

   ute_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_push      (req_push),
      .req_text_byte (req_text_byte),
      .fifo_full     (fifo_full),
      .req_full      (req_full),
      .job_push      (job_push),
      .job           (job)
   );

   ute_job_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (job),
      .pop        (job_pop),
      .full       (fifo_full),
      .head_valid (head_valid),
      .head       (head)
   );

   ute_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head         (head),
      .rsp_pop      (rsp_pop),
      .job_pop      (job_pop),
      .rsp_empty    (rsp_empty),
      .rsp_out_char (rsp_out_char),
      .rsp_run_last (rsp_run_last)
   );

   // The front never offers a job the queue cannot hold.
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !fifo_full)
      else $error("job pushed into a full queue");

   // Every job spells out between one and twelve characters.
   a_job_len: assert property (@(posedge clock) disable iff (reset)
      job_push |-> (job.len != 4'd0) && (job.len <= MAX_LEN))
      else $error("job length out of range");

   // In byte mode a reference always has exactly four lowercase digits.
   a_byte_ref: assert property (@(posedge clock) disable iff (reset)
      (job_push && cfg.byte_mode && job.kind == JOB_REF)
         |-> (job.len == REF_MIN_LEN) && !job.upper)
      else $error("byte mode reference malformed");

   // Nothing is offered on the result side right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result shown right after reset");

   // A job leaves the queue only on the last character of its run.
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> (!rsp_empty && rsp_run_last))
      else $error("job popped without a final character");

endmodule

>>> src/ute_front.sv
// Front part of the escaper: accepts text bytes, tracks UTF-8 sequences, builds jobs.
// Depends on ute_pkg; feeds ute_job_fifo.
module ute_front
   import ute_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_push,
   input  logic [7:0] req_text_byte,
   input  logic       fifo_full,
   output logic       req_full,
   output logic       job_push,
   output job_type    job
);

   logic [2:0]  remaining_ff, remaining_in;
   logic [30:0] acc_ff, acc_in;
   logic [30:0] acc_shift;
   logic        accept;
   logic        job_valid;
   logic [7:0]  c;

   assign c         = req_text_byte;
   assign accept    = req_push & ~fifo_full;
   assign req_full  = fifo_full;
   assign acc_shift = {acc_ff[24:0], c[5:0]};

   always_comb begin
      remaining_in = remaining_ff;
      acc_in       = acc_ff;
      job_valid    = 1'b0;
      job.kind     = JOB_PLAIN;
      job.ch       = c[6:0];
      job.code     = {24'd0, c};
      job.upper    = 1'b0;
      job.len      = PLAIN_LEN;

      if (cfg.byte_mode) begin
         if (c[7]) begin
            job_valid = 1'b1;
            job.kind  = JOB_REF;
            job.len   = REF_FIXED_LEN + ref_digits(job.code);
         end else if (c != 8'd0) begin
            job_valid = 1'b1;
            if (c == BYTE_AMP) begin
               job.kind = JOB_AMP;
               job.len  = AMP_LEN;
            end
         end
      end else if (remaining_ff != 3'd0) begin
         remaining_in = remaining_ff - 3'd1;
         acc_in       = acc_shift;
         if (remaining_ff == 3'd1) begin
            job_valid = 1'b1;
            job.kind  = JOB_REF;
            job.code  = {1'b0, acc_shift};
            job.upper = 1'b1;
            job.len   = REF_FIXED_LEN + ref_digits({1'b0, acc_shift});
            acc_in    = '0;
         end
      end else if (c[7]) begin
         // Lead byte: class comes from the first clear bit among bits 5 to 2.
         if (!c[5]) begin
            remaining_in = 3'd1;
            acc_in       = {26'd0, c[4:0]};
         end else if (!c[4]) begin
            remaining_in = 3'd2;
            acc_in       = {27'd0, c[3:0]};
         end else if (!c[3]) begin
            remaining_in = 3'd3;
            acc_in       = {28'd0, c[2:0]};
         end else if (!c[2]) begin
            remaining_in = 3'd4;
            acc_in       = {29'd0, c[1:0]};
         end else begin
            remaining_in = 3'd5;
            acc_in       = {30'd0, c[0]};
         end
      end else if (c != 8'd0) begin
         job_valid = 1'b1;
         if (c == BYTE_AMP) begin
            job.kind = JOB_AMP;
            job.len  = AMP_LEN;
         end
      end
   end

   assign job_push = accept & job_valid;

   always_ff @(posedge clock) begin
      if (reset || cfg.clear) begin
         remaining_ff <= '0;
         acc_ff       <= '0;
      end else if (accept) begin
         remaining_ff <= remaining_in;
         acc_ff       <= acc_in;
      end
   end

endmodule

>>> src/ute_job_fifo.sv
// Two-entry job queue between the front and the back of the escaper.
// Depends on ute_pkg for the job record.
module ute_job_fifo
   import ute_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output job_type head
);

   job_type    mem [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = mem[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> src/ute_back.sv
// Back part of the escaper: spells out the head job one character per cycle unless the output stalls.
// Depends on ute_pkg; reads jobs from ute_job_fifo and drives the result channel.
module ute_back
   import ute_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head,
   input  logic       rsp_pop,
   output logic       job_pop,
   output logic       rsp_empty,
   output logic [6:0] rsp_out_char,
   output logic       rsp_run_last
);

   logic [3:0] pos_ff, pos_in;
   logic       out_valid_ff, out_valid_in;
   logic [6:0] out_char_ff;
   logic       out_last_ff;
   logic       advance;
   logic       is_last;
   logic [3:0] nib_idx;
   logic [3:0] nib;
   logic [6:0] ch;

   assign advance = head_valid & (~out_valid_ff | rsp_pop);
   assign is_last = (pos_ff == head.len - 4'd1);
   assign nib_idx = head.len - 4'd2 - pos_ff;
   assign nib     = head.code[{nib_idx[2:0], 2'b00} +: 4];

   always_comb begin
      case (head.kind)
         JOB_PLAIN: ch = head.ch;
         JOB_AMP:   ch = amp_char(pos_ff[2:0]);
         JOB_REF: begin
            if (pos_ff == 4'd0) begin
               ch = CH_AMP;
            end else if (pos_ff == 4'd1) begin
               ch = CH_HASH;
            end else if (pos_ff == 4'd2) begin
               ch = CH_X;
            end else if (is_last) begin
               ch = CH_SEMI;
            end else begin
               ch = hex_char(nib, head.upper);
            end
         end
         default:   ch = head.ch;
      endcase
   end

   always_comb begin
      pos_in = pos_ff;
      if (advance) begin
         pos_in = is_last ? 4'd0 : pos_ff + 4'd1;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   assign job_pop      = advance & is_last;
   assign rsp_empty    = ~out_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_run_last = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_char_ff <= ch;
         out_last_ff <= is_last;
      end
   end

endmodule
